>>> src/orsat_pkg.sv
`timescale 1ns / 1ps
package orsat_pkg;

	localparam int ANG_BITS   = 16;
	localparam int HALF_BITS  = 22;
	localparam int Q15_BITS   = 16;
	localparam int AXIS_BITS  = Q15_BITS + 1;
	localparam int CX_BITS    = 34;
	localparam int Z_BITS     = 34;
	localparam int ATAN_N     = 24;
	localparam logic signed [CX_BITS-1:0] GAIN_Q30 = 34'sd652032874;

	function automatic logic signed [Z_BITS-1:0] atan_turn(input logic [4:0] i);
		logic signed [Z_BITS-1:0] r;
		unique case (i)
			5'd0:  r = 34'sh20000000;
			5'd1:  r = 34'sh12E4051E;
			5'd2:  r = 34'sh09FB385B;
			5'd3:  r = 34'sh051111D4;
			5'd4:  r = 34'sh028B0D43;
			5'd5:  r = 34'sh0145D7E1;
			5'd6:  r = 34'sh00A2F61E;
			5'd7:  r = 34'sh00517C55;
			5'd8:  r = 34'sh0028BE53;
			5'd9:  r = 34'sh00145F2F;
			5'd10: r = 34'sh000A2F98;
			5'd11: r = 34'sh000517CC;
			5'd12: r = 34'sh00028BE6;
			5'd13: r = 34'sh000145F3;
			5'd14: r = 34'sh0000A2FA;
			5'd15: r = 34'sh0000517D;
			5'd16: r = 34'sh000028BE;
			5'd17: r = 34'sh0000145F;
			5'd18: r = 34'sh00000A30;
			5'd19: r = 34'sh00000518;
			5'd20: r = 34'sh0000028C;
			5'd21: r = 34'sh00000146;
			5'd22: r = 34'sh000000A3;
			5'd23: r = 34'sh00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [CX_BITS-1:0] x;
		logic signed [CX_BITS-1:0] y;
		logic signed [Z_BITS-1:0]  z;
		logic [1:0]                quad;
	} orsat_rot_t;

endpackage

>>> src/orsat_cell.sv
`timescale 1ns / 1ps
module orsat_cell import orsat_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic       clk,
	input  logic       en,
	input  orsat_rot_t a_in,
	input  orsat_rot_t b_in,
	output orsat_rot_t a_out,
	output orsat_rot_t b_out
);

	function automatic orsat_rot_t rot(input orsat_rot_t v);
		orsat_rot_t r;
		logic signed [CX_BITS-1:0] xs, ys;
		xs = v.x >>> STEP;
		ys = v.y >>> STEP;
		r = v;
		if (!v.z[Z_BITS-1]) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - atan_turn(5'(STEP));
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + atan_turn(5'(STEP));
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			a_out <= rot(a_in);
			b_out <= rot(b_in);
		end
	end

endmodule

>>> src/orsat_proj.sv
`timescale 1ns / 1ps
module orsat_proj import orsat_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [AXIS_BITS-1:0]   ux,
	input  logic signed [AXIS_BITS-1:0]   uy,
	input  logic signed [AXIS_BITS-1:0]   ax [4],
	input  logic signed [AXIS_BITS-1:0]   ay [4],
	input  logic [HALF_BITS-1:0]          half [4],
	input  logic signed [COORD_BITS:0]    dx,
	input  logic signed [COORD_BITS:0]    dy,
	output logic                          sep
);

	localparam int DP_BITS = COORD_BITS + Q15_BITS + 2;
	localparam int DD_BITS = DP_BITS + 15;
	localparam int RP_BITS = 34 + HALF_BITS;
	localparam int RS_BITS = RP_BITS + 2;

	logic signed [DP_BITS-1:0] px_s1, py_s1;
	logic signed [32:0]        dot_s1 [4];
	logic [HALF_BITS-1:0]      half_s1 [4];
	logic [DD_BITS-1:0]        dist_s2;
	logic [RP_BITS-1:0]        rp_s2 [4];
	logic [DD_BITS-1:0]        dist_s3;
	logic [RS_BITS-1:0]        rad_s3;
	logic signed [DP_BITS-1:0] dsum;
	logic [DP_BITS-1:0]        dmag;
	logic [32:0]               dm [4];

	always_comb begin
		dsum = px_s1 + py_s1;
		dmag = dsum[DP_BITS-1] ? DP_BITS'(-dsum) : DP_BITS'(dsum);
		for (int m = 0; m < 4; m++)
			dm[m] = dot_s1[m][32] ? 33'(-dot_s1[m]) : 33'(dot_s1[m]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= DP_BITS'(ux * dx);
			py_s1 <= DP_BITS'(uy * dy);
			for (int m = 0; m < 4; m++) begin
				dot_s1[m] <= 33'(ax[m] * ux) + 33'(ay[m] * uy);
				half_s1[m] <= half[m];
			end
			dist_s2 <= DD_BITS'(dmag) << 15;
			for (int m = 0; m < 4; m++)
				rp_s2[m] <= RP_BITS'(dm[m]) * RP_BITS'(half_s1[m]);
			dist_s3 <= dist_s2;
			rad_s3 <= RS_BITS'(rp_s2[0]) + RS_BITS'(rp_s2[1])
				+ RS_BITS'(rp_s2[2]) + RS_BITS'(rp_s2[3]);
			sep <= (RS_BITS + DD_BITS)'(dist_s3) > (RS_BITS + DD_BITS)'(rad_s3);
		end
	end

endmodule

>>> src/oriented_rect_overlap_sat.sv
`timescale 1ns / 1ps
// channel | direction | handshake     | payload
// in      | to block  | valid / stall | two rectangles: centre, half extents, yaw
// out     | from block| valid / stall | overlap_flag
// Fully pipelined: one transfer per cycle while the output is not stalled. The
// path from input transfer to output transfer runs through the input register, the
// row of CORDIC cells, the axis rounding stage and the four-stage projection unit.
// Reset clears only the valid bits of the pipeline.
// A stall on the output freezes the whole pipeline while the last stage holds a
// result; input stall then follows output stall.
module oriented_rect_overlap_sat import orsat_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_BITS   = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] first_center_x,
	input  logic signed [COORD_BITS-1:0] first_center_y,
	input  logic [HALF_BITS-1:0]         first_half_x,
	input  logic [HALF_BITS-1:0]         first_half_y,
	input  logic [ANG_BITS-1:0]          first_angle,
	input  logic signed [COORD_BITS-1:0] second_center_x,
	input  logic signed [COORD_BITS-1:0] second_center_y,
	input  logic [HALF_BITS-1:0]         second_half_x,
	input  logic [HALF_BITS-1:0]         second_half_y,
	input  logic [ANG_BITS-1:0]          second_angle,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         overlap_flag
);

	localparam int DEPTH = CORDIC_STEPS + 6;

	logic en;
	logic [DEPTH-1:0] vld_q;
	orsat_rot_t ra [CORDIC_STEPS+1];
	orsat_rot_t rb [CORDIC_STEPS+1];
	logic signed [COORD_BITS:0] dx_d [CORDIC_STEPS+1];
	logic signed [COORD_BITS:0] dy_d [CORDIC_STEPS+1];
	logic [HALF_BITS-1:0] h_d [CORDIC_STEPS+1][4];

	assign en        = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	function automatic orsat_rot_t seed(input logic [ANG_BITS-1:0] a);
		orsat_rot_t r;
		r.x = GAIN_Q30;
		r.y = '0;
		r.z = Z_BITS'({a[13:0], 16'h0000});
		r.quad = a[15:14];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ra[0] <= seed(first_angle);
			rb[0] <= seed(second_angle);
			dx_d[0] <= (COORD_BITS+1)'(second_center_x) - (COORD_BITS+1)'(first_center_x);
			dy_d[0] <= (COORD_BITS+1)'(second_center_y) - (COORD_BITS+1)'(first_center_y);
			h_d[0][0] <= first_half_x;
			h_d[0][1] <= first_half_y;
			h_d[0][2] <= second_half_x;
			h_d[0][3] <= second_half_y;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx_d[i+1] <= dx_d[i];
				dy_d[i+1] <= dy_d[i];
				h_d[i+1] <= h_d[i];
			end
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		orsat_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(en),
			.a_in(ra[g]), .b_in(rb[g]),
			.a_out(ra[g+1]), .b_out(rb[g+1])
		);
	end

	function automatic logic signed [Q15_BITS-1:0] sat(input logic signed [CX_BITS-1:0] v);
		if (v > 34'sd32767) return 16'sh7FFF;
		if (v < -34'sd32768) return 16'sh8000;
		return v[Q15_BITS-1:0];
	endfunction

	function automatic logic [2*Q15_BITS-1:0] axis(input orsat_rot_t v);
		logic signed [CX_BITS-1:0] cr, sr, co, so;
		cr = (v.x + 34'sd16384) >>> 15;
		sr = (v.y + 34'sd16384) >>> 15;
		unique case (v.quad)
			2'd1: begin co = -sr; so = cr; end
			2'd2: begin co = -cr; so = -sr; end
			2'd3: begin co = sr; so = -cr; end
			default: begin co = cr; so = sr; end
		endcase
		return {sat(co), sat(so)};
	endfunction

	logic signed [Q15_BITS-1:0] c1_s, s1_s, c2_s, s2_s;
	logic signed [AXIS_BITS-1:0] ax_s [4];
	logic signed [AXIS_BITS-1:0] ay_s [4];
	logic signed [COORD_BITS:0] dx_s, dy_s;
	logic [HALF_BITS-1:0] h_s [4];
	logic [3:0] sep;

	always_ff @(posedge clk) begin
		if (en) begin
			{c1_s, s1_s} <= axis(ra[CORDIC_STEPS]);
			{c2_s, s2_s} <= axis(rb[CORDIC_STEPS]);
			dx_s <= dx_d[CORDIC_STEPS];
			dy_s <= dy_d[CORDIC_STEPS];
			h_s <= h_d[CORDIC_STEPS];
		end
	end

	// one extra bit so that negating -32768 stays exact
	always_comb begin
		ax_s[0] = AXIS_BITS'(c1_s);  ay_s[0] = AXIS_BITS'(s1_s);
		ax_s[1] = -AXIS_BITS'(s1_s); ay_s[1] = AXIS_BITS'(c1_s);
		ax_s[2] = AXIS_BITS'(c2_s);  ay_s[2] = AXIS_BITS'(s2_s);
		ax_s[3] = -AXIS_BITS'(s2_s); ay_s[3] = AXIS_BITS'(c2_s);
	end

	for (genvar k = 0; k < 4; k++) begin : g_axis
		orsat_proj #(.COORD_BITS(COORD_BITS)) u_proj (
			.clk(clk), .en(en),
			.ux(ax_s[k]), .uy(ay_s[k]),
			.ax(ax_s), .ay(ay_s), .half(h_s),
			.dx(dx_s), .dy(dy_s),
			.sep(sep[k])
		);
	end

	assign overlap_flag = ~|sep;

endmodule
